// File: design/psd3_pkg.sv
package psd3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CRD_W     = 32;
    localparam int W_W       = CRD_W + 1;
    localparam int PROD_W    = CRD_W + W_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int NUM_W     = ACC_W - 1 + FRAC_BITS;
    localparam int DEN_W     = 2 * CRD_W;
    localparam int Q_W       = CRD_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int DT_W      = 2 * CRD_W;
    localparam int E_W       = DT_W + 1;
    localparam int DIST_W    = 33;
    localparam int ROOT_W    = DIST_W + FRAC_BITS;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int SQS_W     = SQ_W + 2;
    localparam int EH_W      = ROOT_W / 2;
    localparam int EL_W      = ROOT_W - EH_W;
    localparam int RR_W      = ROOT_W + 3;
    localparam int IDX_W     = 3;

    localparam logic signed [CRD_W-1:0] T_MAX = {1'b0, {(CRD_W-1){1'b1}}};
    localparam logic signed [CRD_W-1:0] T_MIN = {1'b1, {(CRD_W-1){1'b0}}};
    localparam logic signed [CRD_W-1:0] T_ONE = CRD_W'(1 << FRAC_BITS);

    typedef enum logic [IDX_W-1:0] {
        REG_BASE_X = 3'd0,
        REG_BASE_Y = 3'd1,
        REG_BASE_Z = 3'd2,
        REG_DIR_X  = 3'd3,
        REG_DIR_Y  = 3'd4,
        REG_DIR_Z  = 3'd5,
        REG_CLAMP  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] query_x;
        logic signed [CRD_W-1:0] query_y;
        logic signed [CRD_W-1:0] query_z;
    } query_t;

    typedef struct packed {
        logic [DIST_W-1:0]       distance;
        logic signed [CRD_W-1:0] param_t;
        logic                    degenerate;
    } result_t;

    typedef struct packed {
        logic [2:0][CRD_W-1:0] base;
        logic [2:0][CRD_W-1:0] dir;
        logic                  clamp_mode;
    } cfg_t;

    typedef logic [2:0][W_W-1:0] wvec_t;

    typedef struct packed {
        logic  neg;
        logic  degen;
        wvec_t w;
    } div_side_t;

    typedef struct packed {
        logic           ovf;
        logic [Q_W-1:0] quo;
        div_side_t      side;
    } div_res_t;

    typedef struct packed {
        logic                    sat;
        logic [SQ_W-1:0]         sq;
        logic signed [CRD_W-1:0] t;
        logic                    degen;
    } sq_item_t;

endpackage

// File: design/psd3_front.sv
module psd3_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  psd3_pkg::query_t           query,
    input  psd3_pkg::cfg_t             cfg,
    output logic [psd3_pkg::DEN_W-1:0] den,
    output logic                       out_valid,
    output logic [psd3_pkg::NUM_W-1:0] num,
    output psd3_pkg::div_side_t        side
);
    import psd3_pkg::*;

    logic [2:0][CRD_W-1:0]     q_reg;
    wvec_t                     w_reg, w3_reg, w4_reg;
    wvec_t                     w_next;
    logic signed [PROD_W-1:0]  p_reg [3];
    logic signed [PROD_W-1:0]  p_next [3];
    logic signed [DEN_W-1:0]   dsq_reg [3];
    logic signed [DEN_W-1:0]   dsq_next [3];
    logic [DEN_W-1:0]          den_reg;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [ACC_W-1:0]          mag;
    logic [NUM_W-1:0]          num_reg;
    div_side_t                 side_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w_next[i]   = {q_reg[i][CRD_W-1], q_reg[i]}
                        - {cfg.base[i][CRD_W-1], cfg.base[i]};
            p_next[i]   = $signed(cfg.dir[i]) * $signed(w_reg[i]);
            dsq_next[i] = $signed(cfg.dir[i]) * $signed(cfg.dir[i]);
        end
        acc_next = {p_reg[0][PROD_W-1], p_reg[0]} + {p_reg[1][PROD_W-1], p_reg[1]}
                 + {p_reg[2][PROD_W-1], p_reg[2]};
        mag = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= query.query_x;
        q_reg[1] <= query.query_y;
        q_reg[2] <= query.query_z;
        w_reg    <= w_next;
        w3_reg   <= w_reg;
        w4_reg   <= w3_reg;
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]   <= p_next[i];
            dsq_reg[i] <= dsq_next[i];
        end
        den_reg        <= DEN_W'(dsq_reg[0]) + DEN_W'(dsq_reg[1]) + DEN_W'(dsq_reg[2]);
        acc_reg        <= acc_next;
        num_reg        <= {mag[ACC_W-2:0], {FRAC_BITS{1'b0}}};
        side_reg.neg   <= acc_reg[ACC_W-1];
        side_reg.degen <= (den_reg == '0);
        side_reg.w     <= w4_reg;
    end

    assign den       = den_reg;
    assign out_valid = v5_reg;
    assign num       = num_reg;
    assign side      = side_reg;

endmodule

// File: design/psd3_div.sv
module psd3_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [psd3_pkg::NUM_W-1:0] num,
    input  logic [psd3_pkg::DEN_W-1:0] den,
    input  psd3_pkg::div_side_t        side,
    output logic                       out_valid,
    output psd3_pkg::div_res_t         res
);
    import psd3_pkg::*;

    logic [REM_W-1:0] rem_reg  [Q_W+1];
    logic [Q_W-1:0]   quo_reg  [Q_W+1];
    logic [Q_W-1:0]   nl_reg   [Q_W+1];
    logic             ovf_reg  [Q_W+1];
    div_side_t        side_reg [Q_W+1];
    logic             vld_reg  [Q_W+1];
    logic [REM_W-1:0] rem_init;

    assign rem_init = REM_W'(num[NUM_W-1:Q_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem_init;
        ovf_reg[0]  <= (rem_init >= {1'b0, den});
        quo_reg[0]  <= '0;
        nl_reg[0]   <= num[Q_W-1:0];
        side_reg[0] <= side;
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        logic [REM_W-1:0] rsh;
        logic             take;

        always_comb
        begin
            rsh  = {rem_reg[j][REM_W-2:0], nl_reg[j][Q_W-1]};
            take = (rsh >= {1'b0, den});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= take ? (rsh - {1'b0, den}) : rsh;
            quo_reg[j+1]  <= {quo_reg[j][Q_W-2:0], take};
            nl_reg[j+1]   <= {nl_reg[j][Q_W-2:0], 1'b0};
            ovf_reg[j+1]  <= ovf_reg[j];
            side_reg[j+1] <= side_reg[j];
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign res.ovf   = ovf_reg[Q_W];
    assign res.quo   = quo_reg[Q_W];
    assign res.side  = side_reg[Q_W];

endmodule

// File: design/psd3_err.sv
module psd3_err
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  psd3_pkg::div_res_t   div,
    input  psd3_pkg::cfg_t       cfg,
    output logic                 out_valid,
    output psd3_pkg::sq_item_t   item
);
    import psd3_pkg::*;

    logic                    pos_sat, neg_sat;
    logic signed [CRD_W-1:0] t_sat, t_next;
    logic signed [CRD_W-1:0] t_reg [6];
    logic                    dg_reg [6];
    logic                    v_reg [6];
    wvec_t                   w1_reg, w2_reg;
    logic signed [DT_W-1:0]  dt_reg [3];
    logic [E_W-1:0]          e_reg [3];
    logic [E_W-1:0]          e_next [3];
    logic [E_W-1:0]          mag [3];
    logic [2*EH_W-1:0]       hh_reg [3];
    logic [EH_W+EL_W-1:0]    hl_reg [3];
    logic [2*EL_W-1:0]       ll_reg [3];
    logic [2:0]              big4_reg, big5_reg;
    logic [SQ_W-1:0]         sqc_reg [3];
    logic [SQS_W-1:0]        sum;
    logic                    sat_reg;
    logic [SQ_W-1:0]         sq_reg;

    always_comb
    begin
        pos_sat = div.ovf | div.quo[Q_W-1] | div.quo[Q_W-2];
        neg_sat = div.ovf | div.quo[Q_W-1] | (div.quo[Q_W-2] & (|div.quo[Q_W-3:0]));
        if (div.side.neg)
            t_sat = neg_sat ? T_MIN : -$signed(div.quo[CRD_W-1:0]);
        else
            t_sat = pos_sat ? T_MAX : $signed(div.quo[CRD_W-1:0]);
        t_next = t_sat;
        if (cfg.clamp_mode)
        begin
            if (t_sat[CRD_W-1])
                t_next = '0;
            else if (t_sat > T_ONE)
                t_next = T_ONE;
        end
        if (div.side.degen)
            t_next = '0;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_next[i] = {dt_reg[i][DT_W-1], dt_reg[i]}
                      - ({{(E_W-W_W){w2_reg[i][W_W-1]}}, w2_reg[i]} << FRAC_BITS);
            mag[i]    = e_reg[i][E_W-1] ? (~e_reg[i] + E_W'(1)) : e_reg[i];
        end
        sum = SQS_W'(sqc_reg[0]) + SQS_W'(sqc_reg[1]) + SQS_W'(sqc_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < 6; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg[0]  <= t_next;
        dg_reg[0] <= div.side.degen;
        for (int k = 1; k < 6; k++)
        begin
            t_reg[k]  <= t_reg[k-1];
            dg_reg[k] <= dg_reg[k-1];
        end
        w1_reg <= div.side.w;
        w2_reg <= w1_reg;
        for (int i = 0; i < 3; i++)
        begin
            dt_reg[i]   <= $signed(cfg.dir[i]) * t_reg[0];
            e_reg[i]    <= e_next[i];
            big4_reg[i] <= |mag[i][E_W-1:ROOT_W];
            hh_reg[i]   <= mag[i][ROOT_W-1:EL_W] * mag[i][ROOT_W-1:EL_W];
            hl_reg[i]   <= mag[i][ROOT_W-1:EL_W] * mag[i][EL_W-1:0];
            ll_reg[i]   <= mag[i][EL_W-1:0] * mag[i][EL_W-1:0];
            sqc_reg[i]  <= (SQ_W'(hh_reg[i]) << (2 * EL_W))
                         + (SQ_W'(hl_reg[i]) << (EL_W + 1))
                         + SQ_W'(ll_reg[i]);
        end
        big5_reg <= big4_reg;
        sat_reg  <= (|big5_reg) | (|sum[SQS_W-1:SQ_W]);
        sq_reg   <= sum[SQ_W-1:0];
    end

    assign out_valid  = v_reg[5];
    assign item.sat   = sat_reg;
    assign item.sq    = sq_reg;
    assign item.t     = t_reg[5];
    assign item.degen = dg_reg[5];

endmodule

// File: design/psd3_sqrt.sv
module psd3_sqrt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  psd3_pkg::sq_item_t   item,
    output logic                 out_valid,
    output psd3_pkg::result_t    res
);
    import psd3_pkg::*;

    logic [RR_W-1:0]         rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]       root_reg [ROOT_W+1];
    logic [SQ_W-1:0]         sq_reg   [ROOT_W+1];
    logic                    sat_reg  [ROOT_W+1];
    logic signed [CRD_W-1:0] t_reg    [ROOT_W+1];
    logic                    dg_reg   [ROOT_W+1];
    logic                    vld_reg  [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        sq_reg[0]   <= item.sq;
        sat_reg[0]  <= item.sat;
        t_reg[0]    <= item.t;
        dg_reg[0]   <= item.degen;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        logic [RR_W-1:0] rsh;
        logic [RR_W-1:0] trial;
        logic            take;

        always_comb
        begin
            rsh   = {rem_reg[j][RR_W-3:0], sq_reg[j][SQ_W-1:SQ_W-2]};
            trial = RR_W'({root_reg[j], 2'b01});
            take  = (rsh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= take ? (rsh - trial) : rsh;
            root_reg[j+1] <= {root_reg[j][ROOT_W-2:0], take};
            sq_reg[j+1]   <= {sq_reg[j][SQ_W-3:0], 2'b00};
            sat_reg[j+1]  <= sat_reg[j];
            t_reg[j+1]    <= t_reg[j];
            dg_reg[j+1]   <= dg_reg[j];
        end
    end

    assign out_valid      = vld_reg[ROOT_W];
    assign res.distance   = sat_reg[ROOT_W] ? {DIST_W{1'b1}}
                                            : root_reg[ROOT_W][ROOT_W-1:FRAC_BITS];
    assign res.param_t    = t_reg[ROOT_W];
    assign res.degenerate = dg_reg[ROOT_W];

endmodule

// File: design/point_segment_distance_3d_unit.sv
// Point to line / segment distance in 3D, signed Q16.16.
// Configuration: write wr_data to register wr_index while wr_en is high
// (0..2 base point, 3..5 direction, 6 clamp mode). Writes take effect at
// once. The user must make them only while no transaction is in flight;
// the block does not enforce this. Input: a query transaction is taken
// at each rising edge with start high and busy low. busy stays low, so
// one query can enter every cycle.
// Output: done pulses for one cycle with result holding distance, param_t
// and degenerate. There is no backpressure; results must be taken as shown.
// Pipeline: the 33-stage restoring divider for t (one quotient bit per
// stage), the 49-stage square root (one root bit per stage), plus product,
// sum and output stages. Throughput is one query per cycle.
// Reset: valid bits clear, registers return to base 0, direction (1,0,0),
// segment mode; no clearing pass.
module point_segment_distance_3d_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  psd3_pkg::query_t           query,
    output logic                       done,
    output psd3_pkg::result_t          result,
    input  logic                       wr_en,
    input  logic [psd3_pkg::IDX_W-1:0] wr_index,
    input  logic [psd3_pkg::CRD_W-1:0] wr_data
);
    import psd3_pkg::*;

    cfg_t             cfg_reg;
    logic             fr_valid, dv_valid, er_valid, sq_valid;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;
    div_side_t        side;
    div_res_t         dres;
    sq_item_t         sitem;
    result_t          sres;
    result_t          result_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base       <= '0;
            cfg_reg.dir[0]     <= T_ONE;
            cfg_reg.dir[1]     <= '0;
            cfg_reg.dir[2]     <= '0;
            cfg_reg.clamp_mode <= 1'b1;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_BASE_X: cfg_reg.base[0]    <= wr_data;
                REG_BASE_Y: cfg_reg.base[1]    <= wr_data;
                REG_BASE_Z: cfg_reg.base[2]    <= wr_data;
                REG_DIR_X:  cfg_reg.dir[0]     <= wr_data;
                REG_DIR_Y:  cfg_reg.dir[1]     <= wr_data;
                REG_DIR_Z:  cfg_reg.dir[2]     <= wr_data;
                REG_CLAMP:  cfg_reg.clamp_mode <= wr_data[0];
                default:    ;
            endcase
        end
    end

    assign busy = 1'b0;

    psd3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .query     (query),
        .cfg       (cfg_reg),
        .den       (den),
        .out_valid (fr_valid),
        .num       (num),
        .side      (side)
    );

    psd3_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .num       (num),
        .den       (den),
        .side      (side),
        .out_valid (dv_valid),
        .res       (dres)
    );

    psd3_err u_err
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .div       (dres),
        .cfg       (cfg_reg),
        .out_valid (er_valid),
        .item      (sitem)
    );

    psd3_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (er_valid),
        .item      (sitem),
        .out_valid (sq_valid),
        .res       (sres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= sres;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: verif/tb_point_segment_distance_3d_unit.sv
module tb_point_segment_distance_3d_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import psd3_pkg::*;

    localparam int LATENCY   = 96;
    localparam int CYCLE_CAP = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    query_t query;
    logic done;
    result_t result;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CRD_W-1:0] wr_data;

    point_segment_distance_3d_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .query(query),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data)
    );

    logic signed [CRD_W-1:0] line_base [3];
    logic signed [CRD_W-1:0] line_dir [3];
    logic segment_mode;

    result_t pending_results[$];
    int mismatches;
    int cycles;
    int calm_lo, calm_hi;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic result_t nearest_point_distance(query_t q);
        result_t r;
        logic signed [63:0] d [3];
        logic signed [63:0] w [3];
        logic [127:0] den;
        logic signed [127:0] dot;
        logic [127:0] num, quo;
        logic signed [63:0] t;
        logic signed [127:0] e;
        logic [127:0] sq;
        logic [63:0] root;
        logic neg;
        d[0] = line_dir[0]; d[1] = line_dir[1]; d[2] = line_dir[2];
        w[0] = 64'(q.query_x) - 64'(line_base[0]);
        w[1] = 64'(q.query_y) - 64'(line_base[1]);
        w[2] = 64'(q.query_z) - 64'(line_base[2]);
        den = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            den += 128'(d[i] * d[i]);
            dot += 128'(d[i]) * 128'(w[i]);
        end
        t = 0;
        r.degenerate = (den == 0);
        if (den != 0)
        begin
            neg = dot < 0;
            num = neg ? 128'(-dot) : 128'(dot);
            quo = (num << FRAC_BITS) / den;
            if (!neg)
                t = (quo > 128'h7FFFFFFF) ? 64'sh7FFFFFFF : 64'(quo);
            else
                t = (quo > 128'h80000000) ? -64'sh80000000 : -64'(quo);
            if (segment_mode)
            begin
                if (t < 0) t = 0;
                if (t > (64'sd1 <<< FRAC_BITS)) t = 64'sd1 <<< FRAC_BITS;
            end
        end
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            e = 128'(d[i]) * 128'(t) - (128'(w[i]) <<< FRAC_BITS);
            if (e < 0) e = -e;
            sq += 128'(e) * 128'(e);
        end
        root = isqrt128(sq) >> FRAC_BITS;
        r.distance = (root > 64'h1FFFFFFFF) ? 33'h1FFFFFFFF : root[32:0];
        r.param_t = t[31:0];
        return r;
    endfunction

    function automatic bit idle_now();
        return !(cycles >= calm_lo && cycles < calm_hi) && ($urandom_range(99) < 28);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_point_segment_distance_3d_unit: FAIL");
            $finish;
        end
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                result_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.distance !== exp_r.distance || result.param_t !== exp_r.param_t
                    || result.degenerate !== exp_r.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp d=%h t=%h g=%b got d=%h t=%h g=%b",
                                 exp_r.distance, exp_r.param_t, exp_r.degenerate,
                                 result.distance, result.param_t, result.degenerate);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CRD_W-1:0] val);
        @(negedge clk);
        wr_en = 1;
        wr_index = idx;
        wr_data = val;
        case (idx)
            REG_BASE_X: line_base[0] = val;
            REG_BASE_Y: line_base[1] = val;
            REG_BASE_Z: line_base[2] = val;
            REG_DIR_X:  line_dir[0] = val;
            REG_DIR_Y:  line_dir[1] = val;
            REG_DIR_Z:  line_dir[2] = val;
            REG_CLAMP:  segment_mode = val[0];
            default: ;
        endcase
        @(negedge clk);
        wr_en = 0;
    endtask

    task automatic set_line(logic [CRD_W-1:0] bx, logic [CRD_W-1:0] by, logic [CRD_W-1:0] bz,
                            logic [CRD_W-1:0] dx, logic [CRD_W-1:0] dy, logic [CRD_W-1:0] dz,
                            logic cm);
        while (pending_results.size() != 0)
            @(posedge clk);
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
        write_reg(REG_BASE_Z, bz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_CLAMP, {31'd0, cm});
    endtask

    // drives at negedge, accepted at the following posedge
    task automatic send_query(query_t q, bit check_given, result_t given);
        while (idle_now())
        begin
            @(negedge clk);
            start = 0;
        end
        start = 1;
        query = q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(check_given ? given : nearest_point_distance(q));
        @(negedge clk);
        start = 0;
    endtask

    function automatic logic [31:0] rnd_coord(int shape);
        case (shape)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'h100000);
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'h40000);
        endcase
    endfunction

    typedef struct {
        query_t q;
        bit known;
        result_t r;
    } stim_row_t;

    stim_row_t dir_rows[$];

    initial
    begin
        query_t q;
        result_t r;
        int shape;
        mismatches = 0;
        cycles = 0;
        calm_lo = 1000;
        calm_hi = 1400;
        rst_n = 0;
        start = 0;
        query = '0;
        wr_en = 0;
        wr_index = '0;
        wr_data = '0;
        line_base = '{0, 0, 0};
        line_dir = '{32'h10000, 0, 0};
        segment_mode = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // after reset: segment from origin to (1,0,0)
        dir_rows.push_back('{'{32'h8000, 0, 0}, 1, '{33'd0, 32'h8000, 1'b0}});
        dir_rows.push_back('{'{32'h20000, 0, 0}, 1, '{33'h10000, 32'h10000, 1'b0}});
        dir_rows.push_back('{'{32'hFFFF0000, 0, 0}, 1, '{33'h10000, 32'h0, 1'b0}});
        dir_rows.push_back('{'{0, 32'h30000, 0}, 1, '{33'h30000, 32'h0, 1'b0}});
        dir_rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 0, '0});
        dir_rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000}, 0, '0});
        dir_rows.push_back('{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 0, '0});
        foreach (dir_rows[i])
            send_query(dir_rows[i].q, dir_rows[i].known, dir_rows[i].r);

        // zero direction
        set_line(0, 0, 0, 0, 0, 0, 1);
        send_query('{32'h30000, 32'h40000, 0}, 1, '{33'h50000, 32'h0, 1'b1});
        send_query('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 0, '0);
        // infinite line, saturating t both ways
        set_line(0, 0, 0, 1, 0, 0, 0);
        send_query('{32'h7FFFFFFF, 0, 0}, 0, '0);
        send_query('{32'h80000000, 0, 0}, 0, '0);
        send_query('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 0, '0);
        // extreme base and direction, largest distance
        set_line(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 0);
        send_query('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 0, '0);
        send_query('{32'h80000000, 32'h7FFFFFFF, 32'h0}, 0, '0);
        set_line(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1);
        send_query('{32'h80000000, 32'h80000000, 32'h80000000}, 0, '0);
        set_line(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h80000000, 32'h80000000, 1);
        send_query('{32'h80000000, 32'h7FFFFFFF, 32'h12345678}, 0, '0);
        send_query('{32'h0, 32'h0, 32'h0}, 0, '0);

        for (int phase = 0; phase < 12; phase++)
        begin
            shape = $urandom_range(3);
            set_line(rnd_coord(shape), rnd_coord(shape), rnd_coord(shape),
                     (phase == 5) ? 32'h0 : rnd_coord(shape), rnd_coord(shape),
                     (phase == 5) ? 32'h0 : rnd_coord(shape), phase[0]);
            if (phase == 5)
                write_reg(REG_DIR_Y, 32'h0);
            for (int k = 0; k < 50; k++)
            begin
                shape = $urandom_range(3);
                q.query_x = rnd_coord(shape);
                q.query_y = rnd_coord(shape);
                q.query_z = rnd_coord(shape);
                send_query(q, 0, r);
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_point_segment_distance_3d_unit: PASS");
        else
            $display("tb_point_segment_distance_3d_unit: FAIL");
        $finish;
    end
endmodule

// File: files.f
design/psd3_pkg.sv
design/psd3_front.sv
design/psd3_div.sv
design/psd3_err.sv
design/psd3_sqrt.sv
design/point_segment_distance_3d_unit.sv
verif/tb_point_segment_distance_3d_unit.sv
